[rtl/core/gcbfs_pkg.sv]
// Shared constants, types and compare function for the grid clearance search.
package gcbfs_pkg;

  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int DIST_BITS  = 16;
  localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int CRD_W      = 6;
  localparam int STEP_W     = 12;
  localparam int SIZE_W     = 7;
  localparam int IDX_W      = 12;
  localparam int VAL_W      = 16;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  localparam logic [1:0] MV_UP    = 2'd0;
  localparam logic [1:0] MV_DOWN  = 2'd1;
  localparam logic [1:0] MV_LEFT  = 2'd2;
  localparam logic [1:0] MV_RIGHT = 2'd3;

  typedef struct packed {
    logic [DIST_BITS-1:0] clearance;
    logic [STEP_W-1:0]    steps;
    logic [CNT_W-1:0]     seq;
    logic [CRD_W-1:0]     row;
    logic [CRD_W-1:0]     col;
  } entry_t;

  // a ahead of b: larger clearance, then fewer steps, then earlier insert
  function automatic logic goes_first(entry_t a, entry_t b);
    logic r;
    if (a.clearance != b.clearance) r = (a.clearance > b.clearance);
    else if (a.steps != b.steps) r = (a.steps < b.steps);
    else r = (a.seq < b.seq);
    return r;
  endfunction

  typedef enum logic [4:0] {
    S_IDLE, S_CLEAR, S_START, S_START_W, S_PUSH, S_PUSH_CMP,
    S_POP, S_POP_LAST, S_POP_LAST_W, S_SIFT, S_SIFT_L, S_SIFT_R,
    S_SIFT_CMP, S_SIFT_END, S_GOAL, S_NB, S_NB_W, S_NB_NEXT, S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    HR_PARENT, HR_ROOT, HR_LAST, HR_LEFT, HR_RIGHT
  } hrd_t;

  typedef enum logic [1:0] {
    HW_NEW, HW_MOVE, HW_BEST, HW_LAST
  } hwr_t;

  typedef struct packed {
    logic load_search;
    logic write_cell;
    logic clr_step;
    logic cell_nb;
    logic map_rd;
    logic mark;
    logic new_start;
    logic new_nb;
    logic heap_rd;
    hrd_t rd_sel;
    logic heap_wr;
    hwr_t wr_sel;
    logic i_parent;
    logic pop_take;
    logic last_take;
    logic best_l;
    logic best_r;
    logic i_best;
    logic set_found;
    logic k_clear;
    logic k_inc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic start_bad;
    logic heap_empty;
    logic i_zero;
    logic e_first;
    logic l_out;
    logic r_in;
    logic r_first;
    logic best_first;
    logic cnt_nz;
    logic at_goal;
    logic nb_ok;
    logic nb_free;
    logic k_last;
  } sts_t;

endpackage

[rtl/core/gcbfs_dp.sv]
// Datapath: map, visited and heap memories, search registers, result register.
module gcbfs_dp import gcbfs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [CRD_W-1:0]   in_cell_row,
  input  logic [CRD_W-1:0]   in_cell_col,
  input  logic [VAL_W-1:0]   in_cell_value,
  input  logic [CRD_W-1:0]   in_start_row,
  input  logic [CRD_W-1:0]   in_start_col,
  input  logic [CRD_W-1:0]   in_goal_row,
  input  logic [CRD_W-1:0]   in_goal_col,
  input  logic               cfg_wr,
  input  logic               cfg_index,
  input  logic [SIZE_W-1:0]  cfg_data,
  output logic               out_found,
  output logic [STEP_W-1:0]  out_steps,
  output logic [IDX_W-1:0]   out_cell_index
);

  logic [DIST_BITS-1:0] map_mem [CELL_COUNT];
  logic                 vis_mem [CELL_COUNT];
  entry_t               heap_mem [CELL_COUNT];

  logic [SIZE_W-1:0]    cfg_rows_r, cfg_cols_r;
  logic [SIZE_W-1:0]    rows_r, cols_r, rows_eff, cols_eff;
  logic [CRD_W-1:0]     sr_r, sc_r, gr_r, gc_r;
  logic [ADDR_W-1:0]    caddr_r;
  logic [DIST_BITS-1:0] clr_q;
  logic                 vis_q;
  entry_t               rdata_q, new_r, cur_r, last_r, best_r;
  logic [CNT_W-1:0]     count_r, seq_r, i_r, bidx_r;
  logic [1:0]           k_r;
  logic                 found_r;

  logic [CNT_W:0]       l_idx, r_idx;
  logic [CNT_W-1:0]     parent;
  logic [CRD_W-1:0]     nb_row, nb_col;
  logic                 nb_ok;
  logic [ADDR_W-1:0]    start_addr, nb_addr, cell_addr, hr_addr, load_addr;
  logic [STEP_W-1:0]    nb_steps;
  entry_t               wr_data;
  logic [IDX_W-1:0]     span, idx_val;
  logic [CRD_W-1:0]     rep_row, rep_col;

  // size clamp: zero counts as one, above the storage counts as the storage
  always_comb begin
    if (cfg_rows_r == '0) rows_eff = SIZE_W'(1);
    else if ({2'b00, cfg_rows_r} > 9'(MAX_ROWS)) rows_eff = SIZE_W'(MAX_ROWS);
    else rows_eff = cfg_rows_r;
    if (cfg_cols_r == '0) cols_eff = SIZE_W'(1);
    else if ({2'b00, cfg_cols_r} > 9'(MAX_COLS)) cols_eff = SIZE_W'(MAX_COLS);
    else cols_eff = cfg_cols_r;
  end

  assign l_idx   = {i_r, 1'b1};
  assign r_idx   = l_idx + (CNT_W+1)'(1);
  assign parent  = (i_r - CNT_W'(1)) >> 1;

  always_comb begin
    nb_row = cur_r.row;
    nb_col = cur_r.col;
    nb_ok  = 1'b0;
    case (k_r)
      MV_UP: begin
        nb_row = cur_r.row - CRD_W'(1);
        nb_ok  = (cur_r.row != '0);
      end
      MV_DOWN: begin
        nb_row = cur_r.row + CRD_W'(1);
        nb_ok  = ({1'b0, cur_r.row} + SIZE_W'(1)) < rows_r;
      end
      MV_LEFT: begin
        nb_col = cur_r.col - CRD_W'(1);
        nb_ok  = (cur_r.col != '0);
      end
      MV_RIGHT: begin
        nb_col = cur_r.col + CRD_W'(1);
        nb_ok  = ({1'b0, cur_r.col} + SIZE_W'(1)) < cols_r;
      end
      default: nb_ok = 1'b0;
    endcase
  end

  assign start_addr = ADDR_W'(ADDR_W'(sr_r) * ADDR_W'(MAX_COLS)) + ADDR_W'(sc_r);
  assign nb_addr    = ADDR_W'(ADDR_W'(nb_row) * ADDR_W'(MAX_COLS)) + ADDR_W'(nb_col);
  assign load_addr  = ADDR_W'(ADDR_W'(in_cell_row) * ADDR_W'(MAX_COLS))
                      + ADDR_W'(in_cell_col);
  assign cell_addr  = cmd.cell_nb ? nb_addr : start_addr;
  assign nb_steps   = (cur_r.steps == '1) ? cur_r.steps : cur_r.steps + STEP_W'(1);

  always_comb begin
    case (cmd.rd_sel)
      HR_PARENT: hr_addr = parent[ADDR_W-1:0];
      HR_ROOT:   hr_addr = '0;
      HR_LAST:   hr_addr = ADDR_W'(count_r - CNT_W'(1));
      HR_LEFT:   hr_addr = l_idx[ADDR_W-1:0];
      HR_RIGHT:  hr_addr = r_idx[ADDR_W-1:0];
      default:   hr_addr = '0;
    endcase
    case (cmd.wr_sel)
      HW_NEW:  wr_data = new_r;
      HW_MOVE: wr_data = rdata_q;
      HW_BEST: wr_data = best_r;
      HW_LAST: wr_data = last_r;
      default: wr_data = new_r;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.write_cell && ({3'b000, in_cell_row} < 9'(MAX_ROWS))
        && ({3'b000, in_cell_col} < 9'(MAX_COLS))) begin
      map_mem[load_addr] <= DIST_BITS'(in_cell_value);
    end
    if (cmd.map_rd) clr_q <= map_mem[cell_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) vis_mem[caddr_r] <= 1'b0;
    else if (cmd.mark) vis_mem[cell_addr] <= 1'b1;
    if (cmd.map_rd) vis_q <= vis_mem[cell_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.heap_wr) heap_mem[i_r[ADDR_W-1:0]] <= wr_data;
    if (cmd.heap_rd) rdata_q <= heap_mem[hr_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_rows_r <= SIZE_W'(64);
      cfg_cols_r <= SIZE_W'(64);
      count_r    <= '0;
      seq_r      <= '0;
      k_r        <= '0;
      found_r    <= 1'b0;
      caddr_r    <= '0;
    end else begin
      if (cfg_wr && cfg_index == CFG_ROWS) cfg_rows_r <= cfg_data;
      if (cfg_wr && cfg_index == CFG_COLS) cfg_cols_r <= cfg_data;
      if (cmd.load_search) begin
        count_r <= '0;
        seq_r   <= '0;
        found_r <= 1'b0;
        caddr_r <= '0;
      end
      if (cmd.clr_step) caddr_r <= caddr_r + ADDR_W'(1);
      if (cmd.new_start || cmd.new_nb) begin
        count_r <= count_r + CNT_W'(1);
        seq_r   <= seq_r + CNT_W'(1);
      end
      if (cmd.pop_take) count_r <= count_r - CNT_W'(1);
      if (cmd.set_found) found_r <= 1'b1;
      if (cmd.k_clear) k_r <= '0;
      else if (cmd.k_inc) k_r <= k_r + 2'd1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_search) begin
      rows_r <= rows_eff;
      cols_r <= cols_eff;
      sr_r   <= in_start_row;
      sc_r   <= in_start_col;
      gr_r   <= in_goal_row;
      gc_r   <= in_goal_col;
    end
    if (cmd.new_start) begin
      new_r <= '{clearance: clr_q, steps: '0, seq: seq_r, row: sr_r, col: sc_r};
      i_r   <= count_r;
    end
    if (cmd.new_nb) begin
      new_r <= '{clearance: clr_q, steps: nb_steps, seq: seq_r, row: nb_row, col: nb_col};
      i_r   <= count_r;
    end
    if (cmd.i_parent) i_r <= parent;
    if (cmd.pop_take) begin
      cur_r <= rdata_q;
      i_r   <= '0;
    end
    if (cmd.last_take) last_r <= rdata_q;
    if (cmd.best_l) begin
      best_r <= rdata_q;
      bidx_r <= l_idx[CNT_W-1:0];
    end
    if (cmd.best_r) begin
      best_r <= rdata_q;
      bidx_r <= r_idx[CNT_W-1:0];
    end
    if (cmd.i_best) i_r <= bidx_r;
    if (cmd.out_load) begin
      out_found      <= found_r;
      out_steps      <= found_r ? cur_r.steps : '0;
      out_cell_index <= idx_val;
    end
  end

  // bottom-up row-major index, wrapping to 12 bits
  assign rep_row = found_r ? cur_r.row : sr_r;
  assign rep_col = found_r ? cur_r.col : sc_r;
  assign span    = IDX_W'(rows_r) - IDX_W'(rep_row) - IDX_W'(1);
  assign idx_val = IDX_W'(span * IDX_W'(cols_r)) + IDX_W'(rep_col);

  assign sts.clr_done   = (caddr_r == '1);
  assign sts.start_bad  = ({1'b0, sr_r} >= rows_r) || ({1'b0, sc_r} >= cols_r);
  assign sts.heap_empty = (count_r == '0);
  assign sts.i_zero     = (i_r == '0);
  assign sts.e_first    = goes_first(new_r, rdata_q);
  assign sts.l_out      = (l_idx >= {1'b0, count_r});
  assign sts.r_in       = (r_idx < {1'b0, count_r});
  assign sts.r_first    = goes_first(rdata_q, best_r);
  assign sts.best_first = goes_first(best_r, last_r);
  assign sts.cnt_nz     = (count_r != '0);
  assign sts.at_goal    = (cur_r.row == gr_r) && (cur_r.col == gc_r);
  assign sts.nb_ok      = nb_ok;
  assign sts.nb_free    = (clr_q != '0) && !vis_q;
  assign sts.k_last     = (k_r == MV_RIGHT);

endmodule

[rtl/core/gcbfs_ctrl.sv]
// Controller: search sequencer state machine and handshake control.
module gcbfs_ctrl import gcbfs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_mode,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   ret_nb_r, ret_nb_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_xfer, out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_nb_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_nb_r    <= ret_nb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt     = state_r;
    ret_nb_nxt    = ret_nb_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE:       if (in_xfer && in_mode == MODE_SEARCH) state_nxt = S_CLEAR;
      S_CLEAR:      if (sts.clr_done) state_nxt = S_START;
      S_START:      state_nxt = sts.start_bad ? S_FINISH : S_START_W;
      S_START_W: begin
        ret_nb_nxt = 1'b0;
        state_nxt  = S_PUSH;
      end
      S_PUSH: begin
        if (!sts.i_zero) state_nxt = S_PUSH_CMP;
        else state_nxt = ret_nb_r ? S_NB_NEXT : S_POP;
      end
      S_PUSH_CMP: begin
        if (sts.e_first) state_nxt = S_PUSH;
        else state_nxt = ret_nb_r ? S_NB_NEXT : S_POP;
      end
      S_POP:        state_nxt = sts.heap_empty ? S_FINISH : S_POP_LAST;
      S_POP_LAST:   state_nxt = S_POP_LAST_W;
      S_POP_LAST_W: state_nxt = S_SIFT;
      S_SIFT:       state_nxt = sts.l_out ? S_SIFT_END : S_SIFT_L;
      S_SIFT_L:     state_nxt = sts.r_in ? S_SIFT_R : S_SIFT_CMP;
      S_SIFT_R:     state_nxt = S_SIFT_CMP;
      S_SIFT_CMP:   state_nxt = sts.best_first ? S_SIFT : S_SIFT_END;
      S_SIFT_END:   state_nxt = S_GOAL;
      S_GOAL:       state_nxt = sts.at_goal ? S_FINISH : S_NB;
      S_NB:         state_nxt = sts.nb_ok ? S_NB_W : S_NB_NEXT;
      S_NB_W: begin
        if (sts.nb_free) begin
          ret_nb_nxt = 1'b1;
          state_nxt  = S_PUSH;
        end else begin
          state_nxt = S_NB_NEXT;
        end
      end
      S_NB_NEXT:    state_nxt = sts.k_last ? S_POP : S_NB;
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default:      state_nxt = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd        = '0;
    cmd.rd_sel = HR_ROOT;
    cmd.wr_sel = HW_NEW;
    case (state_r)
      S_IDLE: begin
        cmd.write_cell  = in_xfer && in_mode == MODE_LOAD;
        cmd.load_search = in_xfer && in_mode == MODE_SEARCH;
      end
      S_CLEAR:   cmd.clr_step = 1'b1;
      S_START:   cmd.map_rd = !sts.start_bad;
      S_START_W: begin
        cmd.new_start = 1'b1;
        cmd.mark      = 1'b1;
      end
      S_PUSH: begin
        if (sts.i_zero) begin
          cmd.heap_wr = 1'b1;
          cmd.wr_sel  = HW_NEW;
        end else begin
          cmd.heap_rd = 1'b1;
          cmd.rd_sel  = HR_PARENT;
        end
      end
      S_PUSH_CMP: begin
        cmd.heap_wr = 1'b1;
        if (sts.e_first) begin
          cmd.wr_sel   = HW_MOVE;
          cmd.i_parent = 1'b1;
        end else begin
          cmd.wr_sel = HW_NEW;
        end
      end
      S_POP: begin
        cmd.heap_rd = !sts.heap_empty;
        cmd.rd_sel  = HR_ROOT;
      end
      S_POP_LAST: begin
        cmd.heap_rd  = 1'b1;
        cmd.rd_sel   = HR_LAST;
        cmd.pop_take = 1'b1;
      end
      S_POP_LAST_W: cmd.last_take = 1'b1;
      S_SIFT: begin
        cmd.heap_rd = !sts.l_out;
        cmd.rd_sel  = HR_LEFT;
      end
      S_SIFT_L: begin
        cmd.best_l  = 1'b1;
        cmd.heap_rd = sts.r_in;
        cmd.rd_sel  = HR_RIGHT;
      end
      S_SIFT_R:  cmd.best_r = sts.r_first;
      S_SIFT_CMP: begin
        if (sts.best_first) begin
          cmd.heap_wr = 1'b1;
          cmd.wr_sel  = HW_BEST;
          cmd.i_best  = 1'b1;
        end
      end
      S_SIFT_END: begin
        cmd.heap_wr = sts.cnt_nz;
        cmd.wr_sel  = HW_LAST;
      end
      S_GOAL: begin
        cmd.set_found = sts.at_goal;
        cmd.k_clear   = 1'b1;
      end
      S_NB: begin
        cmd.cell_nb = 1'b1;
        cmd.map_rd  = sts.nb_ok;
      end
      S_NB_W: begin
        cmd.cell_nb = 1'b1;
        cmd.new_nb  = sts.nb_free;
        cmd.mark    = sts.nb_free;
      end
      S_NB_NEXT: cmd.k_inc = 1'b1;
      S_FINISH:  cmd.out_load = out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

[rtl/core/grid_clearance_best_first_search.sv]
// Top level: greedy best-first search over a loaded 4-connected clearance grid.
// Map load: one transfer per cycle while idle, no result. Search: visited-map
//   clear, then pops, neighbors tried and pushes that climb the heap level by level;
//   one result transfer follows through a registered output.
// Heap and map memories have one read and one write port, which sets the pace.
// Reset (rst_n low, synchronous): idle, no pending result, grid 64x64.
//   Map contents are undefined until loaded.
module grid_clearance_best_first_search import gcbfs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_mode,
  input  logic [5:0]        in_cell_row,
  input  logic [5:0]        in_cell_col,
  input  logic [15:0]       in_cell_value,
  input  logic [5:0]        in_start_row,
  input  logic [5:0]        in_start_col,
  input  logic [5:0]        in_goal_row,
  input  logic [5:0]        in_goal_col,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_found,
  output logic [11:0]       out_steps,
  output logic [11:0]       out_cell_index,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [6:0]        cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // config writes land at any time; the user must issue them only while idle, the block does not enforce this
  assign cfg_ready = 1'b1;

  gcbfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gcbfs_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_cell_row    (in_cell_row),
    .in_cell_col    (in_cell_col),
    .in_cell_value  (in_cell_value),
    .in_start_row   (in_start_row),
    .in_start_col   (in_start_col),
    .in_goal_row    (in_goal_row),
    .in_goal_col    (in_goal_col),
    .cfg_wr         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_found      (out_found),
    .out_steps      (out_steps),
    .out_cell_index (out_cell_index)
  );

endmodule
